/* hw/rtl/hermite_curve_point_generator_defines.svh */
// ----------------------------------------------------------------------------
// Hermite curve point generator assertion macros
// Shared concurrent assertion forms; they compile to nothing when assertions
// are switched off for a build.
// ----------------------------------------------------------------------------
`ifndef HERMITE_CURVE_POINT_GENERATOR_DEFINES_SVH
`define HERMITE_CURVE_POINT_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define HCPG_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcpg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HCPG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcpg assertion failed");

`else

`define HCPG_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define HCPG_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/hcpg_pkg.sv */
// ----------------------------------------------------------------------------
// Hermite curve point generator package
// Types and fixed constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package hcpg_pkg;

    // Request command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Pixel coordinates are always 14-bit signed.
    localparam int PIX_BITS = 14;
    localparam logic signed [PIX_BITS-1:0] PIX_MAX = 14'sd8191;
    localparam logic signed [PIX_BITS-1:0] PIX_MIN = -14'sd8192;

    // Number of stored segment vector components.
    localparam int NUM_VEC = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CUBE,
        ST_WEIGHT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SUM_Y,
        ST_ROUND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic square;
        logic cube;
        logic weight;
        logic mul_x;
        logic mul_y;
        logic sum_y;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
    } dp_status_t;

endpackage

/* hw/rtl/hcpg_controller.sv */
// ----------------------------------------------------------------------------
// Hermite curve point generator controller
// Accepts requests, sequences one point evaluation through the datapath and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
`include "hermite_curve_point_generator_defines.svh"

module hcpg_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   request_valid,
    input  logic                   command,
    output logic                   request_stall,
    output logic                   point_valid,
    input  logic                   point_stall,
    output hcpg_pkg::dp_cmd_t      cmd,
    input  hcpg_pkg::dp_status_t   status
);

    hcpg_pkg::state_t state_reg;
    hcpg_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcpg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        request_stall = 1'b1;
        accept        = 1'b0;
        unique case (state_reg)
            hcpg_pkg::ST_IDLE:
            begin
                request_stall = 1'b0;
                accept        = request_valid;
                if (accept)
                begin
                    if (command == hcpg_pkg::CMD_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (status.active)
                    begin
                        state_next = hcpg_pkg::ST_SQUARE;
                    end
                end
            end
            hcpg_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = hcpg_pkg::ST_CUBE;
            end
            hcpg_pkg::ST_CUBE:
            begin
                cmd.cube   = 1'b1;
                state_next = hcpg_pkg::ST_WEIGHT;
            end
            hcpg_pkg::ST_WEIGHT:
            begin
                cmd.weight = 1'b1;
                state_next = hcpg_pkg::ST_MUL_X;
            end
            hcpg_pkg::ST_MUL_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = hcpg_pkg::ST_MUL_Y;
            end
            hcpg_pkg::ST_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = hcpg_pkg::ST_SUM_Y;
            end
            hcpg_pkg::ST_SUM_Y:
            begin
                cmd.sum_y  = 1'b1;
                state_next = hcpg_pkg::ST_ROUND;
            end
            hcpg_pkg::ST_ROUND:
            begin
                // Wait here while the previous point still sits unread.
                if (!out_valid_reg || !point_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = hcpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !point_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign point_valid = out_valid_reg;

    `HCPG_ASSERT_SAME(a_finish_has_room, clk, rst_n, cmd.finish, !out_valid_reg || !point_stall)
    `HCPG_ASSERT_NEXT(a_round_gives_point, clk, rst_n, cmd.finish, out_valid_reg)
    `HCPG_ASSERT_NEXT(a_idle_step_ignored, clk, rst_n, accept && command == hcpg_pkg::CMD_STEP && !status.active, state_reg == hcpg_pkg::ST_IDLE)

endmodule

/* hw/rtl/hcpg_datapath.sv */
// ----------------------------------------------------------------------------
// Hermite curve point generator datapath
// Holds the segment, the curve parameter and the step register, and computes
// the powers of t, the basis weights, the weighted sums and the pixel values.
// ----------------------------------------------------------------------------
`include "hermite_curve_point_generator_defines.svh"

module hcpg_datapath #(
    parameter int COORD_BITS  = 12,
    parameter int T_FRAC_BITS = 20
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  hcpg_pkg::dp_cmd_t                      cmd,
    output hcpg_pkg::dp_status_t                   status,
    input  logic                                   cfg_write,
    input  logic [T_FRAC_BITS:0]                   cfg_data,
    input  logic signed [COORD_BITS-1:0]           start_x,
    input  logic signed [COORD_BITS-1:0]           start_y,
    input  logic signed [COORD_BITS-1:0]           end_x,
    input  logic signed [COORD_BITS-1:0]           end_y,
    input  logic signed [COORD_BITS-1:0]           start_tangent_x,
    input  logic signed [COORD_BITS-1:0]           start_tangent_y,
    input  logic signed [COORD_BITS-1:0]           end_tangent_x,
    input  logic signed [COORD_BITS-1:0]           end_tangent_y,
    input  logic signed [COORD_BITS-1:0]           shift_x,
    input  logic signed [COORD_BITS-1:0]           shift_y,
    output logic signed [hcpg_pkg::PIX_BITS-1:0]   pixel_x,
    output logic signed [hcpg_pkg::PIX_BITS-1:0]   pixel_y,
    output logic                                   last_point
);

    localparam int T_BITS    = T_FRAC_BITS + 1;
    localparam int WGT_BITS  = T_FRAC_BITS + 4;
    localparam int PROD_BITS = WGT_BITS + COORD_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam int QUO_BITS  = ACC_BITS - T_FRAC_BITS;

    localparam logic [T_BITS-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [T_BITS-1:0] T_STEP_RESET =
        T_BITS'(((64'd1 << T_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [QUO_BITS-1:0] Q_MAX = QUO_BITS'(hcpg_pkg::PIX_MAX);
    localparam logic signed [QUO_BITS-1:0] Q_MIN = QUO_BITS'(hcpg_pkg::PIX_MIN);

    // Control state.
    logic [T_BITS-1:0]                     t_step_reg;
    logic [T_BITS-1:0]                     t_reg;
    logic                                  active_reg;

    // Segment and evaluation payload.
    logic signed [COORD_BITS-1:0]          vec_reg [hcpg_pkg::NUM_VEC];
    logic signed [COORD_BITS-1:0]          shift_reg [2];
    logic [T_BITS-1:0]                     t2_reg;
    logic [T_BITS-1:0]                     t3_reg;
    logic signed [WGT_BITS-1:0]            wgt_reg [4];
    logic signed [PROD_BITS-1:0]           prod_reg [4];
    logic signed [ACC_BITS-1:0]            acc_reg [2];
    logic signed [hcpg_pkg::PIX_BITS-1:0]  pixel_x_reg;
    logic signed [hcpg_pkg::PIX_BITS-1:0]  pixel_y_reg;
    logic                                  last_reg;

    logic [T_BITS-1:0]                     t_mul_a;
    logic [2*T_BITS-1:0]                   t_mul_full;
    logic [T_BITS-1:0]                     t2_next;
    logic [T_BITS-1:0]                     t3_next;
    logic signed [WGT_BITS-1:0]            t_s;
    logic signed [WGT_BITS-1:0]            t2_s;
    logic signed [WGT_BITS-1:0]            t3_s;
    logic signed [WGT_BITS-1:0]            one_s;
    logic signed [WGT_BITS-1:0]            wgt_next [4];
    logic signed [PROD_BITS-1:0]           prod_next [4];
    logic signed [COORD_BITS-1:0]          shift_sel;
    logic signed [ACC_BITS-1:0]            acc_next;
    logic signed [hcpg_pkg::PIX_BITS-1:0]  pix_next [2];
    logic [T_BITS:0]                       t_adv_next;
    logic                                  last_next;

    // Powers of t, each truncated back to Q1.F. One multiplier forms the
    // square and then the cube.
    assign t_mul_a    = cmd.cube ? t2_reg : t_reg;
    assign t_mul_full = t_mul_a * t_reg;
    assign t2_next    = t_mul_full[T_FRAC_BITS +: T_BITS];
    assign t3_next    = t_mul_full[T_FRAC_BITS +: T_BITS];

    // Hermite basis weights as signed Q.F values.
    assign t_s   = $signed({3'b000, t_reg});
    assign t2_s  = $signed({3'b000, t2_reg});
    assign t3_s  = $signed({3'b000, t3_reg});
    assign one_s = $signed({3'b000, T_ONE});

    assign wgt_next[0] = (t3_s <<< 1) - (t2_s <<< 1) - t2_s + one_s;
    assign wgt_next[1] = (t2_s <<< 1) + t2_s - (t3_s <<< 1);
    assign wgt_next[2] = t3_s - (t2_s <<< 1) + t_s;
    assign wgt_next[3] = t3_s - t2_s;

    // Four product lanes; lane k weights vector pair k, x first, then y.
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        logic signed [COORD_BITS-1:0] operand;
        assign operand      = cmd.mul_y ? vec_reg[2*k+1] : vec_reg[2*k];
        assign prod_next[k] = wgt_reg[k] * operand;
    end

    // One shared adder sums the products and the offset for x, then for y.
    assign shift_sel = cmd.sum_y ? shift_reg[1] : shift_reg[0];
    assign acc_next  = ACC_BITS'(prod_reg[0]) + ACC_BITS'(prod_reg[1])
                     + ACC_BITS'(prod_reg[2]) + ACC_BITS'(prod_reg[3])
                     + (ACC_BITS'(shift_sel) <<< T_FRAC_BITS);

    // Truncation toward zero, then saturation to the pixel range.
    for (genvar k = 0; k < 2; k++)
    begin : g_round
        logic signed [QUO_BITS-1:0] quo;
        logic                       frac_nz;
        logic signed [QUO_BITS-1:0] quo_trunc;
        always_comb
        begin
            quo       = acc_reg[k][ACC_BITS-1:T_FRAC_BITS];
            frac_nz   = |acc_reg[k][T_FRAC_BITS-1:0];
            quo_trunc = quo + QUO_BITS'(acc_reg[k][ACC_BITS-1] & frac_nz);
            if (quo_trunc > Q_MAX)
            begin
                pix_next[k] = hcpg_pkg::PIX_MAX;
            end
            else if (quo_trunc < Q_MIN)
            begin
                pix_next[k] = hcpg_pkg::PIX_MIN;
            end
            else
            begin
                pix_next[k] = quo_trunc[hcpg_pkg::PIX_BITS-1:0];
            end
        end
    end

    assign t_adv_next = {1'b0, t_reg} + {1'b0, t_step_reg};
    assign last_next  = t_adv_next > {1'b0, T_ONE};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_step_reg <= T_STEP_RESET;
            t_reg      <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                t_step_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                t_reg      <= '0;
                active_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                if (last_next)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    t_reg <= t_adv_next[T_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vec_reg[0]   <= start_x;
            vec_reg[1]   <= start_y;
            vec_reg[2]   <= end_x;
            vec_reg[3]   <= end_y;
            vec_reg[4]   <= start_tangent_x;
            vec_reg[5]   <= start_tangent_y;
            vec_reg[6]   <= end_tangent_x;
            vec_reg[7]   <= end_tangent_y;
            shift_reg[0] <= shift_x;
            shift_reg[1] <= shift_y;
        end
        if (cmd.square)
        begin
            t2_reg <= t2_next;
        end
        if (cmd.cube)
        begin
            t3_reg <= t3_next;
        end
        if (cmd.weight)
        begin
            wgt_reg <= wgt_next;
        end
        if (cmd.mul_x || cmd.mul_y)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_y)
        begin
            acc_reg[0] <= acc_next;
        end
        if (cmd.sum_y)
        begin
            acc_reg[1] <= acc_next;
        end
        if (cmd.finish)
        begin
            pixel_x_reg <= pix_next[0];
            pixel_y_reg <= pix_next[1];
            last_reg    <= last_next;
        end
    end

    assign status.active = active_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign last_point    = last_reg;

    `HCPG_ASSERT_SAME(a_t_in_range, clk, rst_n, active_reg, t_reg <= T_ONE)
    `HCPG_ASSERT_SAME(a_finish_armed, clk, rst_n, cmd.finish, active_reg)
    `HCPG_ASSERT_NEXT(a_load_arms, clk, rst_n, cmd.load, active_reg && t_reg == '0)

endmodule

/* hw/rtl/hermite_curve_point_generator.sv */
// ----------------------------------------------------------------------------
// Hermite curve point generator
// A step request on an armed segment walks the evaluation sequence (square,
// cube, weights, x products, y products, y sum, rounding) before its point is
// registered; no new request is accepted until that sequence is done.
// A load request is done in the accepting cycle and gives no point.
// Reset clears the curve parameter and disarms the segment; the step register
// returns to about 0.001. Stored vectors are not cleared.
// ----------------------------------------------------------------------------
module hermite_curve_point_generator #(
    parameter int COORD_BITS  = 12,
    parameter int T_FRAC_BITS = 20
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // Request channel.
    input  logic                                   request_valid,
    output logic                                   request_stall,
    input  logic                                   command,
    input  logic signed [COORD_BITS-1:0]           start_x,
    input  logic signed [COORD_BITS-1:0]           start_y,
    input  logic signed [COORD_BITS-1:0]           end_x,
    input  logic signed [COORD_BITS-1:0]           end_y,
    input  logic signed [COORD_BITS-1:0]           start_tangent_x,
    input  logic signed [COORD_BITS-1:0]           start_tangent_y,
    input  logic signed [COORD_BITS-1:0]           end_tangent_x,
    input  logic signed [COORD_BITS-1:0]           end_tangent_y,
    input  logic signed [COORD_BITS-1:0]           shift_x,
    input  logic signed [COORD_BITS-1:0]           shift_y,

    // Point channel.
    output logic                                   point_valid,
    input  logic                                   point_stall,
    output logic signed [hcpg_pkg::PIX_BITS-1:0]   pixel_x,
    output logic signed [hcpg_pkg::PIX_BITS-1:0]   pixel_y,
    output logic                                   last_point,

    // Step register write channel.
    input  logic                                   step_cfg_valid,
    output logic                                   step_cfg_ready,
    input  logic [T_FRAC_BITS:0]                   t_step
);

    // The controller and the datapath talk only through these two groups.
    hcpg_pkg::dp_cmd_t    cmd;
    hcpg_pkg::dp_status_t status;

    // The step register can always be written; the block is only required to
    // see such writes while it has no request in flight.
    assign step_cfg_ready = 1'b1;

    // The controller accepts a request only when it is idle. A load is done in
    // the accepting cycle. A step on an armed segment walks through seven
    // evaluation states; the last one waits if the previous point has not yet
    // been taken, so the output register decouples the two channels.
    hcpg_controller u_controller (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .command       (command),
        .request_stall (request_stall),
        .point_valid   (point_valid),
        .point_stall   (point_stall),
        .cmd           (cmd),
        .status        (status)
    );

    // The datapath holds the segment and t, shares one t multiplier for the
    // square and the cube, and uses four product lanes and one adder that serve
    // x and then y in turn. Coordinates are truncated toward zero and
    // saturated to the 14-bit pixel range.
    hcpg_datapath #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (step_cfg_valid),
        .cfg_data        (t_step),
        .start_x         (start_x),
        .start_y         (start_y),
        .end_x           (end_x),
        .end_y           (end_y),
        .start_tangent_x (start_tangent_x),
        .start_tangent_y (start_tangent_y),
        .end_tangent_x   (end_tangent_x),
        .end_tangent_y   (end_tangent_y),
        .shift_x         (shift_x),
        .shift_y         (shift_y),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .last_point      (last_point)
    );

endmodule
